>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a condition at every clock edge outside reset.
`define SALLOC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition is followed by another one on the next clock edge.
`define SALLOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SALLOC_ASSERT_ALWAYS(label, expr, msg)
`define SALLOC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/salloc_pkg.sv
// Shared types and codes of the slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package salloc_pkg;

  typedef logic [1:0] status_t;

  // Result status codes.
  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_REJECT  = 2'd1;
  localparam status_t STATUS_DELETED = 2'd2;
  localparam status_t STATUS_FULL    = 2'd3;

  // Request kinds.
  localparam logic KIND_RESERVE = 1'b0;
  localparam logic KIND_DELETE  = 1'b1;

  // Register selects, taken from address bit 2.
  localparam logic REG_ENABLE    = 1'b0;
  localparam logic REG_MAX_ITEMS = 1'b1;

endpackage

`default_nettype wire

>>> rtl/salloc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module salloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/salloc_regs.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module salloc_regs
  import salloc_pkg::*;
#(
  parameter int SLOTS = 1024,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output logic               enable,
  output logic      [CW-1:0] max_items
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b1;
      max_items <= CW'(SLOTS);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ENABLE:    enable    <= pwdata[0];
        REG_MAX_ITEMS: max_items <= pwdata[CW-1:0];
        default:       enable    <= enable;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ENABLE:    prdata = {31'b0, enable};
      REG_MAX_ITEMS: prdata = 32'(max_items);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/salloc_ctrl.sv
// Request sequencer: reads the slot memory, updates the free list and loads the result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module salloc_ctrl
  import salloc_pkg::*;
#(
  parameter int SLOTS = 1024,
  localparam int AW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          enable,
  input  wire logic [CW-1:0] max_items,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          kind,
  input  wire logic [AW-1:0] slot,
  output logic               out_valid,
  input  wire logic          out_ready,
  output status_t            status,
  output logic      [AW-1:0] slot_out,
  output logic      [CW-1:0] free_count,
  output logic               mem_we,
  output logic      [AW-1:0] mem_waddr,
  output logic      [CW:0]   mem_wdata,
  output logic      [AW-1:0] mem_raddr,
  input  wire logic [CW:0]   mem_rdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_LINK = 2'd2;

  localparam logic [CW-1:0] NULL_LINK = CW'(SLOTS);

  logic [1:0]    state, state_next;
  logic          kind_q;
  logic [AW-1:0] slot_q;
  logic [AW-1:0] link_addr, link_addr_next;
  logic [CW-1:0] item_count, count_next;
  logic [CW-1:0] free_head, head_next;
  logic [CW-1:0] free_tail, tail_next;
  logic [CW-1:0] free_total, total_next;

  logic          out_free;
  logic          ld_out;
  status_t       res_status;
  logic [AW-1:0] res_slot;
  logic [CW-1:0] slot_ext;
  logic [CW-1:0] rd_link;
  logic          rd_mark;
  logic [CW-1:0] pop_head;
  logic [CW-1:0] cap;
  logic          head_null;
  logic          tail_null;

  assign in_ready  = (state == ST_IDLE) && !rst;
  assign out_free  = !out_valid || out_ready;
  assign slot_ext  = CW'(slot_q);
  assign rd_link   = mem_rdata[CW-1:0];
  assign rd_mark   = mem_rdata[CW];
  assign pop_head  = (rd_link < NULL_LINK) ? rd_link : NULL_LINK;
  assign cap       = (max_items < NULL_LINK) ? max_items : NULL_LINK;
  assign head_null = (free_head == NULL_LINK);
  assign tail_null = (free_tail == NULL_LINK);

  // The read address stays on the held request while the result waits.
  always_comb begin
    if (state == ST_IDLE) begin
      mem_raddr = (kind == KIND_DELETE) ? slot : free_head[AW-1:0];
    end else begin
      mem_raddr = (kind_q == KIND_DELETE) ? slot_q : free_head[AW-1:0];
    end
  end

  always_comb begin
    state_next     = state;
    link_addr_next = link_addr;
    count_next     = item_count;
    head_next      = free_head;
    tail_next      = free_tail;
    total_next     = free_total;
    ld_out         = 1'b0;
    res_status     = STATUS_OK;
    res_slot       = '0;
    mem_we         = 1'b0;
    mem_waddr      = slot_q;
    mem_wdata      = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        if (out_free) begin
          ld_out     = 1'b1;
          state_next = ST_IDLE;
          if (!enable) begin
            res_status = STATUS_REJECT;
          end else if (kind_q == KIND_DELETE) begin
            if (slot_ext >= item_count) begin
              res_status = STATUS_REJECT;
            end else if (rd_mark) begin
              res_status = STATUS_DELETED;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = slot_q;
              mem_wdata = {1'b1, NULL_LINK};
              res_slot  = slot_q;
              tail_next = slot_ext;
              if (tail_null) begin
                head_next = slot_ext;
              end else begin
                // The old tail still has to point at the new one.
                state_next     = ST_LINK;
                link_addr_next = free_tail[AW-1:0];
              end
              if (free_total < NULL_LINK) begin
                total_next = free_total + CW'(1);
              end
            end
          end else if (!head_null) begin
            mem_we    = 1'b1;
            mem_waddr = free_head[AW-1:0];
            mem_wdata = {1'b0, rd_link};
            res_slot  = free_head[AW-1:0];
            head_next = pop_head;
            if (pop_head == NULL_LINK) begin
              tail_next = NULL_LINK;
            end
            if (free_total != '0) begin
              total_next = free_total - CW'(1);
            end
          end else if (item_count >= cap) begin
            res_status = STATUS_FULL;
          end else begin
            // A new slot starts with its mark cleared.
            mem_we     = 1'b1;
            mem_waddr  = item_count[AW-1:0];
            mem_wdata  = {1'b0, NULL_LINK};
            res_slot   = item_count[AW-1:0];
            count_next = item_count + CW'(1);
          end
        end
      end
      ST_LINK: begin
        mem_we     = 1'b1;
        mem_waddr  = link_addr;
        mem_wdata  = {1'b1, slot_ext};
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      item_count <= '0;
      free_head  <= NULL_LINK;
      free_tail  <= NULL_LINK;
      free_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      item_count <= count_next;
      free_head  <= head_next;
      free_tail  <= tail_next;
      free_total <= total_next;
      if (ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    link_addr <= link_addr_next;
    if (in_valid && in_ready) begin
      kind_q <= kind;
      slot_q <= slot;
    end
    if (ld_out) begin
      status     <= res_status;
      slot_out   <= res_slot;
      free_count <= total_next;
    end
  end

  `SALLOC_ASSERT_ALWAYS(a_total_within_pool, free_total <= item_count, "free count exceeds pool")
  `SALLOC_ASSERT_ALWAYS(a_head_tail_agree, head_null == tail_null, "free list ends disagree")
  `SALLOC_ASSERT_ALWAYS(a_empty_list_count, head_null == (free_total == '0), "free count off")
  `SALLOC_ASSERT_NEXT(a_accept_reads, in_valid && in_ready, state == ST_RD, "request not read")
  `SALLOC_ASSERT_NEXT(a_link_one_cycle, state == ST_LINK, state == ST_IDLE, "link write stuck")

endmodule

`default_nettype wire

>>> rtl/slot_allocator_fifo_free_list_core.sv
// Top level of the FIFO free-list slot allocator.
`timescale 1ns / 1ps
`default_nettype none

// Slot allocator for one pool of SLOTS item slots. A reserve request (kind 0)
// hands out the oldest freed slot and clears its deleted mark; when no freed
// slot waits it grows the pool by one slot at its end, up to the smaller of
// max_items and SLOTS, and answers status 3 once that limit is reached. A
// delete request (kind 1) answers status 1 when the slot lies at or above the
// current item count and status 2 when it is already marked; otherwise it marks
// the slot and appends it to the tail of the free list. With enable low every
// request answers status 1 and leaves the state alone. Each request yields one
// result transfer carrying the status, the slot (0 on failure) and the number of
// freed slots waiting after the request. The free list is linked through one
// synchronous memory of SLOTS entries, each holding the deleted mark and the
// next link; entries at or above the item count are never used, and a slot's
// entry is written with a cleared mark when the pool grows over it, so no
// clearing pass follows reset and requests are taken right away. Requests are
// handled one at a time: each takes one memory read, then the update and
// write-back, and a delete onto a non-empty free list then writes the link
// of the old tail in a separate step through the single write port.
// A finished result sits in an output register, so the next request transfer
// is taken while that result still waits. Registers: enable at byte address 0
// (reset 1) and max_items at byte address 4 (reset SLOTS); write them only
// while no request is in flight.
module slot_allocator_fifo_free_list_core
  import salloc_pkg::*;
#(
  parameter int SLOTS = 1024,
  localparam int AW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // Configuration port.
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  // Request channel.
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          kind,
  input  wire logic [AW-1:0] slot,
  // Result channel.
  output logic               out_valid,
  input  wire logic          out_ready,
  output status_t            status,
  output logic      [AW-1:0] slot_out,
  output logic      [CW-1:0] free_count
);

  logic          enable;
  logic [CW-1:0] max_items;

  // Slot memory port: each entry is {deleted mark, next link}.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CW:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [CW:0]   mem_rdata;

  salloc_regs #(
    .SLOTS(SLOTS)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .enable   (enable),
    .max_items(max_items)
  );

  salloc_ram #(
    .WIDTH(CW + 1),
    .DEPTH(SLOTS)
  ) u_slot_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  salloc_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .enable    (enable),
    .max_items (max_items),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .slot      (slot),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .slot_out  (slot_out),
    .free_count(free_count),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

`default_nettype wire
